// ===== design/pnmes_pkg.sv =====
package pnmes_pkg;

  // field widths
  localparam int IDX_W   = 10;
  localparam int COORD_W = 13;
  localparam int DIST_W  = 14;
  localparam int TOTAL_W = 24;

  // square and root datapath widths
  localparam int SQR_W      = 2 * COORD_W;
  localparam int SUMSQ_W    = SQR_W + 1;
  localparam int RAD_W      = 2 * DIST_W;
  localparam int REM_W      = DIST_W + 2;
  localparam int SQRT_ITERS = DIST_W;
  localparam int ITER_W     = $clog2(SQRT_ITERS);

  // mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_SELF = 1'b1;

  // sequencer states
  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RDSRC = 10'b0000000100,
    S_RDDST = 10'b0000001000,
    S_DIFF  = 10'b0000010000,
    S_SQX   = 10'b0000100000,
    S_SQY   = 10'b0001000000,
    S_ROOT  = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

endpackage

// ===== design/pnmes_ram.sv =====
module pnmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/per_node_min_edge_sum_top.sv =====
// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------------
// item in   | start (in), busy (out) | mode_i, airport_index_i, dest_index_i,
//           |                        | coord_x_i, coord_y_i
// result    | done_o (1-cycle pulse) | status_o, edge_distance_o, new_minimum_o,
//           |                        | total_of_minima_o
//
// an item is taken at a clock edge with start high and busy low
// load, self-connection and out-of-range items: 1 cycle of work, done_o in the next cycle
// connection items: 20 cycles of work (3 memory reads, two squares on one 13x13 multiplier,
//   14 iterations of the bit-pair root unit, 1 min update), done_o in the next cycle
// busy drops in the done_o cycle, so the next item may be taken at the edge ending it
// after reset the min store is cleared one entry a cycle: busy for AIRPORT_COUNT cycles
// done_o is not held: the receiver takes each result in its one cycle
module per_node_min_edge_sum_top
  import pnmes_pkg::*;
#(
  parameter int AIRPORT_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [IDX_W-1:0]   airport_index_i,
  input  logic [IDX_W-1:0]   dest_index_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  output logic               done_o,
  output logic               status_o,
  output logic [DIST_W-1:0]  edge_distance_o,
  output logic               new_minimum_o,
  output logic [TOTAL_W-1:0] total_of_minima_o
);

  localparam int AddrW = $clog2(AIRPORT_COUNT);

  state_e state_q, state_d;

  logic [AddrW-1:0]   clr_q, clr_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               done_q, done_d;

  logic               load_q, status_q;
  logic [IDX_W-1:0]   src_q, dst_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [COORD_W-1:0] sx_q, sy_q, dx_q, dy_q;
  logic [DIST_W:0]    ed_q;
  logic [SQR_W-1:0]   acc_q;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rem_q;
  logic [DIST_W-1:0]  root_q;
  logic [ITER_W-1:0]  it_q;

  logic               res_status_q, res_newmin_q;
  logic [DIST_W-1:0]  res_dist_q;
  logic [TOTAL_W-1:0] res_total_q;

  logic accept, src_ok, dst_ok, edge_go;
  logic [AddrW-1:0] src_addr, dst_addr;

  // accept decode and range checks
  assign accept   = start && (state_q == S_IDLE);
  assign src_ok   = 32'(airport_index_i) < AIRPORT_COUNT;
  assign dst_ok   = 32'(dest_index_i) < AIRPORT_COUNT;
  assign edge_go  = (mode_i == MODE_EDGE) && (airport_index_i != dest_index_i)
                    && src_ok && dst_ok;
  assign src_addr = AddrW'(32'(src_q));
  assign dst_addr = AddrW'(32'(dst_q));

  // coordinate store: {x, y}
  logic                     crd_we, crd_re;
  logic [AddrW-1:0]         crd_raddr;
  logic [2*COORD_W-1:0]     crd_rdata;
  logic [COORD_W-1:0]       rd_x, rd_y;

  assign crd_we    = (state_q == S_FIN) && load_q;
  assign crd_re    = (state_q == S_RDSRC) || (state_q == S_RDDST);
  assign crd_raddr = (state_q == S_RDSRC) ? src_addr : dst_addr;
  assign rd_x      = crd_rdata[2*COORD_W-1:COORD_W];
  assign rd_y      = crd_rdata[COORD_W-1:0];

  pnmes_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(AIRPORT_COUNT)
  ) u_crd_ram (
    .clk_i  (clk_i),
    .we_i   (crd_we),
    .waddr_i(src_addr),
    .wdata_i({cx_q, cy_q}),
    .re_i   (crd_re),
    .raddr_i(crd_raddr),
    .rdata_o(crd_rdata)
  );

  // per-source store: {has connection, shortest distance}
  logic                edge_we, take;
  logic [AddrW-1:0]    edge_waddr;
  logic [DIST_W:0]     edge_wdata, edge_rdata;
  logic [DIST_W-1:0]   old_min;
  logic signed [DIST_W:0] delta;

  assign old_min = ed_q[DIST_W] ? ed_q[DIST_W-1:0] : '0;
  assign take    = !ed_q[DIST_W] || (root_q < ed_q[DIST_W-1:0]);
  assign delta   = signed'({1'b0, root_q}) - signed'({1'b0, old_min});

  assign edge_we    = (state_q == S_CLEAR) || ((state_q == S_UPD) && take);
  assign edge_waddr = (state_q == S_CLEAR) ? clr_q : src_addr;
  assign edge_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, root_q};

  pnmes_ram #(
    .WIDTH(DIST_W + 1),
    .DEPTH(AIRPORT_COUNT)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .re_i   (state_q == S_RDSRC),
    .raddr_i(src_addr),
    .rdata_o(edge_rdata)
  );

  // shared squaring multiplier
  logic [COORD_W-1:0] mul_op;
  logic [SQR_W-1:0]   mul_prod;
  logic [SUMSQ_W-1:0] sum_sq;

  assign mul_op   = (state_q == S_SQY) ? dy_q : dx_q;
  assign mul_prod = SQR_W'(mul_op) * SQR_W'(mul_op);
  assign sum_sq   = SUMSQ_W'(acc_q) + SUMSQ_W'(mul_prod);

  // one bit-pair step of the integer square root
  logic [REM_W+1:0] rem_sh, trial, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    total_d = total_q;
    done_d  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(AIRPORT_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = edge_go ? S_RDSRC : S_FIN;
        end
      end
      S_RDSRC: state_d = S_RDDST;
      S_RDDST: state_d = S_DIFF;
      S_DIFF:  state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_ROOT;
      S_ROOT: begin
        if (it_q == ITER_W'(SQRT_ITERS - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (take) begin
          total_d = total_q + TOTAL_W'(delta);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q    <= airport_index_i;
      dst_q    <= dest_index_i;
      cx_q     <= coord_x_i;
      cy_q     <= coord_y_i;
      load_q   <= (mode_i == MODE_LOAD) && src_ok;
      status_q <= ((mode_i == MODE_EDGE) && (airport_index_i == dest_index_i))
                  ? STATUS_SELF : STATUS_OK;
    end
    if (state_q == S_RDDST) begin
      sx_q <= rd_x;
      sy_q <= rd_y;
      ed_q <= edge_rdata;
    end
    if (state_q == S_DIFF) begin
      dx_q <= (sx_q > rd_x) ? sx_q - rd_x : rd_x - sx_q;
      dy_q <= (sy_q > rd_y) ? sy_q - rd_y : rd_y - sy_q;
    end
    if (state_q == S_SQX) begin
      acc_q <= mul_prod;
    end
    if (state_q == S_SQY) begin
      rad_q  <= RAD_W'(sum_sq);
      rem_q  <= '0;
      root_q <= '0;
      it_q   <= '0;
    end
    if (state_q == S_ROOT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[DIST_W-2:0], ge};
      it_q   <= it_q + 1'b1;
    end
    if (state_q == S_UPD) begin
      res_status_q <= STATUS_OK;
      res_dist_q   <= root_q;
      res_newmin_q <= take;
      res_total_q  <= total_d;
    end
    if (state_q == S_FIN) begin
      res_status_q <= status_q;
      res_dist_q   <= '0;
      res_newmin_q <= 1'b0;
      res_total_q  <= total_q;
    end
  end

  // outputs
  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = res_status_q;
  assign edge_distance_o   = res_dist_q;
  assign new_minimum_o     = res_newmin_q;
  assign total_of_minima_o = res_total_q;

endmodule

// ===== design/pnmes_checker.sv =====
module pnmes_checker
  import pnmes_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               mode_i,
  input logic [IDX_W-1:0]   airport_index_i,
  input logic [IDX_W-1:0]   dest_index_i,
  input logic [COORD_W-1:0] coord_x_i,
  input logic [COORD_W-1:0] coord_y_i,
  input logic               done_o,
  input logic               status_o,
  input logic [DIST_W-1:0]  edge_distance_o,
  input logic               new_minimum_o,
  input logic [TOTAL_W-1:0] total_of_minima_o
);

  // a taken item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after taking an item");

  // the result cycle frees the block
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("block still busy while a result is shown");

  // an ignored self-connection reports no distance and no new minimum
  a_self_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_SELF) |-> (edge_distance_o == '0) && !new_minimum_o)
    else $error("self-connection result carries a distance or a new minimum");

  // a new minimum is part of the total
  a_min_in_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && new_minimum_o |-> TOTAL_W'(edge_distance_o) <= total_of_minima_o)
    else $error("total below the new minimum it contains");

endmodule

bind per_node_min_edge_sum_top pnmes_checker u_pnmes_checker (.*);

// ===== test/tb_per_node_min_edge_sum_top.sv =====
module tb_per_node_min_edge_sum_top;
  import pnmes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AIRPORTS       = 1024;
  localparam int HOT_COUNT      = 16;
  localparam int ITEMS_PER_PASS = 284;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP        = 25;
  localparam int SETTLE_CYCLES  = 40;

  // one result of the block
  typedef struct packed {
    logic               status;
    logic [DIST_W-1:0]  distance;
    logic               new_min;
    logic [TOTAL_W-1:0] total;
  } edge_report_t;

  // one row of the directed stimulus, with its expected result where typed in
  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   src;
    logic [IDX_W-1:0]   dst;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               typed;
    edge_report_t       report;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 24;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               mode_i = MODE_LOAD;
  logic [IDX_W-1:0]   airport_index_i = '0;
  logic [IDX_W-1:0]   dest_index_i = '0;
  logic [COORD_W-1:0] coord_x_i = '0;
  logic [COORD_W-1:0] coord_y_i = '0;
  logic               done_o;
  logic               status_o;
  logic [DIST_W-1:0]  edge_distance_o;
  logic               new_minimum_o;
  logic [TOTAL_W-1:0] total_of_minima_o;

  // predicted airport table and per-source minima
  logic [COORD_W-1:0] pos_x [AIRPORTS];
  logic [COORD_W-1:0] pos_y [AIRPORTS];
  bit                 src_connected [AIRPORTS];
  logic [DIST_W-1:0]  src_min [AIRPORTS];
  logic [TOTAL_W-1:0] minima_sum = '0;

  // airports whose coordinates have been written, for legal connections
  bit                 loaded [AIRPORTS];
  int                 loaded_list [$];

  edge_report_t       reports_due [$];
  edge_report_t       observed;
  edge_report_t       oldest;
  int                 mismatches = 0;
  int                 stalled_cycles = 0;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // extremes: opposite corners, both directions, then an equal distance
    '{MODE_LOAD, 10'd0,    10'd1023, 13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd0,     1'b0, 24'd0}},
    '{MODE_LOAD, 10'd1023, 10'd0,    13'd8191, 13'd8191, 1'b1,
      '{STATUS_OK,   14'd0,     1'b0, 24'd0}},
    '{MODE_EDGE, 10'd0,    10'd1023, 13'd8191, 13'd8191, 1'b1,
      '{STATUS_OK,   14'd11583, 1'b1, 24'd11583}},
    '{MODE_EDGE, 10'd1023, 10'd0,    13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd11583, 1'b1, 24'd23166}},
    '{MODE_EDGE, 10'd0,    10'd1023, 13'd4095, 13'd1,    1'b1,
      '{STATUS_OK,   14'd11583, 1'b0, 24'd23166}},
    // smaller connection replaces the minimum, self-connection ignored
    '{MODE_LOAD, 10'd5,    10'd1000, 13'd8191, 13'd0,    1'b1,
      '{STATUS_OK,   14'd0,     1'b0, 24'd23166}},
    '{MODE_EDGE, 10'd0,    10'd5,    13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd8191,  1'b1, 24'd19774}},
    '{MODE_EDGE, 10'd5,    10'd5,    13'd0,    13'd0,    1'b1,
      '{STATUS_SELF, 14'd0,     1'b0, 24'd19774}},
    // coincident airports give a zero distance, then a 3-4-5 pair and an equal distance
    '{MODE_LOAD, 10'd512,  10'd511,  13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd0,     1'b0, 24'd19774}},
    '{MODE_EDGE, 10'd0,    10'd512,  13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd0,     1'b1, 24'd11583}},
    '{MODE_LOAD, 10'd682,  10'd341,  13'd3,    13'd4,    1'b1,
      '{STATUS_OK,   14'd0,     1'b0, 24'd11583}},
    '{MODE_EDGE, 10'd682,  10'd0,    13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd5,     1'b1, 24'd11588}},
    '{MODE_EDGE, 10'd682,  10'd512,  13'd0,    13'd0,    1'b1,
      '{STATUS_OK,   14'd5,     1'b0, 24'd11588}},
    // the rest goes through the predictor
    '{MODE_EDGE, 10'd5,    10'd1023, 13'd0,    13'd0,    1'b0, '0},
    '{MODE_LOAD, 10'd341,  10'd682,  13'd5461, 13'd2730, 1'b0, '0},
    '{MODE_EDGE, 10'd341,  10'd682,  13'd0,    13'd0,    1'b0, '0},
    '{MODE_EDGE, 10'd341,  10'd1023, 13'd0,    13'd0,    1'b0, '0},
    '{MODE_LOAD, 10'd0,    10'd0,    13'd8191, 13'd8191, 1'b0, '0},
    '{MODE_EDGE, 10'd0,    10'd1023, 13'd0,    13'd0,    1'b0, '0},
    '{MODE_EDGE, 10'd1023, 10'd0,    13'd0,    13'd0,    1'b0, '0},
    '{MODE_EDGE, 10'd1023, 10'd1023, 13'd0,    13'd0,    1'b0, '0},
    '{MODE_EDGE, 10'd512,  10'd5,    13'd0,    13'd0,    1'b0, '0},
    '{MODE_LOAD, 10'd1,    10'd1022, 13'd1,    13'd8190, 1'b0, '0},
    '{MODE_EDGE, 10'd1,    10'd5,    13'd0,    13'd0,    1'b0, '0}
  };

  per_node_min_edge_sum_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .airport_index_i   (airport_index_i),
    .dest_index_i      (dest_index_i),
    .coord_x_i         (coord_x_i),
    .coord_y_i         (coord_y_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .edge_distance_o   (edge_distance_o),
    .new_minimum_o     (new_minimum_o),
    .total_of_minima_o (total_of_minima_o)
  );

  always #6 clk_i = ~clk_i;

  // floor square root, two bits of the radicand per step
  function automatic logic [DIST_W-1:0] floor_sqrt(input logic [SUMSQ_W-1:0] radicand);
    int unsigned rem;
    int unsigned root;
    int unsigned probe;
    rem = 32'(radicand);
    root = 0;
    probe = 32'd1 << 30;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[DIST_W-1:0];
  endfunction

  // apply one item to the predicted tables and return its result
  function automatic edge_report_t route_outcome(input logic m, input int src, input int dst,
                                                 input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    edge_report_t r;
    int unsigned dx;
    int unsigned dy;
    r = '{STATUS_OK, '0, 1'b0, '0};
    if (m == MODE_LOAD) begin
      if (src < AIRPORTS) begin
        pos_x[src] = x;
        pos_y[src] = y;
      end
    end else if (src == dst) begin
      r.status = STATUS_SELF;
    end else if (src < AIRPORTS && dst < AIRPORTS) begin
      dx = (pos_x[src] > pos_x[dst]) ? 32'(pos_x[src] - pos_x[dst])
                                     : 32'(pos_x[dst] - pos_x[src]);
      dy = (pos_y[src] > pos_y[dst]) ? 32'(pos_y[src] - pos_y[dst])
                                     : 32'(pos_y[dst] - pos_y[src]);
      r.distance = floor_sqrt(SUMSQ_W'(dx * dx + dy * dy));
      if (!src_connected[src]) begin
        src_connected[src] = 1'b1;
        src_min[src] = r.distance;
        minima_sum = minima_sum + TOTAL_W'(r.distance);
        r.new_min = 1'b1;
      end else if (r.distance < src_min[src]) begin
        minima_sum = minima_sum - TOTAL_W'(src_min[src]) + TOTAL_W'(r.distance);
        src_min[src] = r.distance;
        r.new_min = 1'b1;
      end
    end
    r.total = minima_sum;
    return r;
  endfunction

  // present one item, hold it until taken, then record what it should produce
  task automatic send_item(input logic m, input int src, input int dst,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic typed, input edge_report_t typed_report);
    edge_report_t predicted;
    start           <= 1'b1;
    mode_i          <= m;
    airport_index_i <= IDX_W'(src);
    dest_index_i    <= IDX_W'(dst);
    coord_x_i       <= x;
    coord_y_i       <= y;
    do @(posedge clk_i); while (busy);
    predicted = route_outcome(m, src, dst, x, y);
    reports_due.push_back(typed ? typed_report : predicted);
    if (m == MODE_LOAD && !loaded[src]) begin
      loaded[src] = 1'b1;
      loaded_list.push_back(src);
    end
  endtask

  // sender gap of random length, taken with the given percentage
  task automatic maybe_idle(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
  endtask

  // hold off until every outstanding item has produced its result
  task automatic drain_results();
    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      observed = '{status_o, edge_distance_o, new_minimum_o, total_of_minima_o};
      if (reports_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: status %0d distance %0d new_min %0d total %0d",
                   observed.status, observed.distance, observed.new_min, observed.total);
      end else begin
        oldest = reports_due.pop_front();
        if (observed.status !== oldest.status || observed.distance !== oldest.distance ||
            observed.new_min !== oldest.new_min || observed.total !== oldest.total) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: exp status %0d distance %0d new_min %0d total %0d,",
                      " got %0d %0d %0d %0d"},
                     oldest.status, oldest.distance, oldest.new_min, oldest.total,
                     observed.status, observed.distance, observed.new_min, observed.total);
        end
      end
    end
  end

  // watchdog on cycles where neither an item nor a result moves
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || (rst_ni && done_o)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int hot [HOT_COUNT];
    int pass_idle [3];
    int pick;
    int src;
    int dst;
    logic m;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pass_idle = '{17, 69, 0};
    foreach (hot[i]) hot[i] = $urandom_range(0, AIRPORTS - 1);

    // reset, once
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_table[i].mode, directed_table[i].src, directed_table[i].dst,
                directed_table[i].x, directed_table[i].y, directed_table[i].typed,
                directed_table[i].report);
      maybe_idle(20);
    end
    drain_results();

    // random part: loads, self-connections and connections over a small set of busy sources
    for (int pass = 0; pass < 3; pass++) begin
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        pick = $urandom_range(0, 99);
        x = COORD_W'($urandom_range(0, 8191));
        y = COORD_W'($urandom_range(0, 8191));
        dst = $urandom_range(0, AIRPORTS - 1);
        if (pick < 30) begin
          m = MODE_LOAD;
          src = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, HOT_COUNT - 1)]
                                             : $urandom_range(0, AIRPORTS - 1);
          if ($urandom_range(0, 99) < 20) begin
            x = ($urandom_range(0, 1) != 0) ? 13'd8191 : COORD_W'($urandom_range(0, 3));
            y = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'd8191;
          end
        end else if (pick < 38) begin
          m = MODE_EDGE;
          src = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          dst = src;
        end else begin
          m = MODE_EDGE;
          src = hot[$urandom_range(0, HOT_COUNT - 1)];
          if (!loaded[src] || $urandom_range(0, 99) < 40)
            src = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          do dst = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          while (dst == src);
        end
        send_item(m, src, dst, x, y, 1'b0, '0);
        maybe_idle(pass_idle[pass]);
      end
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
